/* rtl/biba_pkg.sv */
// shared types and constants for the bitmap inode/block allocator
package biba_pkg;
  localparam int MapWords      = 512;
  localparam int WordAw        = $clog2(MapWords);
  localparam int MaxFileBlocks = 12;
  localparam int BlockBytes    = 4096;
  localparam int BlockShift    = $clog2(BlockBytes);
  localparam int NeedW         = $clog2(MaxFileBlocks + 1);
  localparam logic [31:0] MaxBytes = 32'(MaxFileBlocks * BlockBytes);

  localparam logic [2:0] OP_LOAD_INODE = 3'd0;
  localparam logic [2:0] OP_LOAD_DATA  = 3'd1;
  localparam logic [2:0] OP_READ_INODE = 3'd2;
  localparam logic [2:0] OP_READ_DATA  = 3'd3;
  localparam logic [2:0] OP_ADD_FILE   = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TOO_LARGE = 2'd1;
  localparam logic [1:0] ST_NO_INODE  = 2'd2;
  localparam logic [1:0] ST_NO_DATA   = 2'd3;

  localparam logic [1:0] REG_INODE_TOTAL = 2'd0;
  localparam logic [1:0] REG_DATA_TOTAL  = 2'd1;
  localparam logic [1:0] REG_DATA_BASE   = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_RD_WAIT, S_IRD, S_ISCAN, S_DRD, S_DSCAN,
    S_MARK, S_MARK_WR, S_EMIT_ST, S_EMIT_BLK, S_EMIT_ONE
  } state_t;

  typedef struct packed {
    logic clear_step;   // write zero at sweep address, advance
    logic load_item;    // capture input item
    logic addr_zero;    // reset scan address
    logic addr_inc;     // advance scan address
    logic rd_inode;     // issue inode map read at scan address
    logic rd_data;      // issue data map read at scan address
    logic rd_req;       // issue read at request index
    logic ino_take;     // record found inode bit
    logic dat_take;     // record lowest free data bit of the word
    logic mark_rd;      // read data word holding the next block to mark
    logic mark_step;    // write back one marked data bit
    logic ino_mark;     // write back the marked inode bit
    logic emit_inc;     // next block result
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic too_large;
    logic [2:0] op;
    logic ino_hit;      // free inode bit in current word
    logic ino_end;      // scan address past the last searchable word
    logic dat_hit;      // free data bit left in current word
    logic dat_done;     // this take completes the needed blocks
    logic dat_end;
    logic need_zero;
    logic mark_done;
    logic emit_last;
  } sts_t;
endpackage

/* rtl/biba_if.sv */
// valid/ready channel interfaces
interface biba_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [8:0]  word_index;
  logic [63:0] word_value;
  logic [31:0] file_size_bytes;
  modport source (output valid, opcode, word_index, word_value, file_size_bytes, input ready);
  modport sink (input valid, opcode, word_index, word_value, file_size_bytes, output ready);
endinterface

interface biba_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] inode_number;
  logic [31:0] block_address;
  logic        is_block;
  logic [63:0] read_value;
  logic        last;
  modport source (output valid, status, inode_number, block_address, is_block, read_value,
                  last, input ready);
  modport sink (input valid, status, inode_number, block_address, is_block, read_value,
                last, output ready);
endinterface

interface biba_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/bitmap_inode_block_allocator_unit.sv */
// top level of the bitmap inode/block allocator
// add file scans the inode map word by word, then the data map, taking free blocks from
// each data word, marks the taken blocks and the inode bit, then emits a status and one
// result per block; every map access goes through the single read port of each map
// after reset a clearing pass zeroes both maps before any item is taken;
// configuration registers reset to zero
module bitmap_inode_block_allocator_unit (
  input logic clk,
  input logic rst,
  biba_in_if.sink    in_ch,
  biba_out_if.source out_ch,
  biba_cfg_if.sink   cfg
);
  import biba_pkg::*;
  state_t state;
  cmd_t   cmd;
  sts_t   sts;

  // configuration is always taken
  assign cfg.ready = 1'b1;

  biba_ctrl u_ctrl (
    .clk, .rst,
    .in_valid (in_ch.valid), .in_ready (in_ch.ready),
    .out_valid (out_ch.valid), .out_ready (out_ch.ready),
    .state_o (state), .cmd, .sts
  );

  biba_dp u_dp (
    .clk, .rst, .state, .cmd, .sts,
    .opcode (in_ch.opcode), .word_index (in_ch.word_index),
    .word_value (in_ch.word_value), .file_size_bytes (in_ch.file_size_bytes),
    .cfg_we (cfg.valid), .cfg_index (cfg.index), .cfg_data (cfg.data),
    .status (out_ch.status), .inode_number (out_ch.inode_number),
    .block_address (out_ch.block_address), .is_block (out_ch.is_block),
    .read_value (out_ch.read_value), .last (out_ch.last)
  );
endmodule

/* rtl/biba_ctrl.sv */
// sequencer for clearing, map access, searches and result emission
module biba_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output biba_pkg::state_t state_o,
  output biba_pkg::cmd_t  cmd,
  input  biba_pkg::sts_t  sts
);
  import biba_pkg::*;
  state_t state, state_next;
  assign state_o = state;

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          cmd.addr_zero = 1'b1;
          state_next = S_RD_WAIT;
        end
      end
      S_RD_WAIT: begin
        // item registered; decide path
        if (sts.op == OP_ADD_FILE && !sts.too_large) begin
          cmd.rd_inode = 1'b1;
          cmd.addr_inc = 1'b1;
          state_next = S_IRD;
        end else if (sts.op == OP_READ_INODE || sts.op == OP_READ_DATA) begin
          cmd.rd_req = 1'b1;
          state_next = S_IRD;
        end else begin
          state_next = S_EMIT_ONE;
        end
      end
      S_IRD: begin
        if (sts.op != OP_ADD_FILE) state_next = S_EMIT_ONE;
        else state_next = S_ISCAN;
      end
      S_ISCAN: begin
        if (sts.ino_hit) begin
          cmd.ino_take = 1'b1;
          cmd.addr_zero = 1'b1;
          state_next = S_DRD;
        end else if (sts.ino_end) begin
          state_next = S_EMIT_ONE;
        end else begin
          cmd.rd_inode = 1'b1;
          cmd.addr_inc = 1'b1;
          state_next = S_IRD;
        end
      end
      S_DRD: begin
        if (sts.need_zero) state_next = S_MARK;
        else begin
          cmd.rd_data = 1'b1;
          cmd.addr_inc = 1'b1;
          state_next = S_DSCAN;
        end
      end
      S_DSCAN: begin
        // one free bit taken per cycle until the word runs out or the needed blocks are found
        if (sts.dat_hit) begin
          cmd.dat_take = 1'b1;
          if (sts.dat_done) begin
            cmd.addr_zero = 1'b1;
            state_next = S_MARK;
          end
        end else if (sts.dat_end) state_next = S_EMIT_ONE;
        else state_next = S_DRD;
      end
      S_MARK: begin
        if (sts.mark_done) begin
          cmd.ino_mark = 1'b1;
          state_next = S_EMIT_ST;
        end else begin
          cmd.mark_rd = 1'b1;
          state_next = S_MARK_WR;
        end
      end
      S_MARK_WR: begin
        cmd.mark_step = 1'b1;
        cmd.addr_inc = 1'b1;
        state_next = S_MARK;
      end
      S_EMIT_ST: begin
        out_valid = 1'b1;
        if (out_ready) state_next = sts.need_zero ? S_IDLE : S_EMIT_BLK;
      end
      S_EMIT_BLK: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.emit_inc = 1'b1;
          if (sts.emit_last) state_next = S_IDLE;
        end
      end
      S_EMIT_ONE: begin
        out_valid = 1'b1;
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

/* rtl/biba_dp.sv */
// bitmap memories, scan registers and result formatting
module biba_dp (
  input  logic             clk,
  input  logic             rst,
  input  biba_pkg::state_t state,
  input  biba_pkg::cmd_t   cmd,
  output biba_pkg::sts_t   sts,
  input  logic [2:0]       opcode,
  input  logic [8:0]       word_index,
  input  logic [63:0]      word_value,
  input  logic [31:0]      file_size_bytes,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [31:0]      cfg_data,
  output logic [1:0]       status,
  output logic [15:0]      inode_number,
  output logic [31:0]      block_address,
  output logic             is_block,
  output logic [63:0]      read_value,
  output logic             last
);
  import biba_pkg::*;
  localparam int BitW = WordAw + 6;

  logic [63:0] imem [MapWords];
  logic [63:0] dmem [MapWords];
  logic [63:0] irdata, drdata;

  logic [15:0] inode_total, data_total;
  logic [31:0] data_base;
  logic [2:0]  op;
  logic [8:0]  idx;
  logic        too_large;
  logic [NeedW-1:0] need, nf, emit_cnt;
  logic [WordAw:0] addr, cur;   // next word to read, word being examined
  logic [WordAw:0] clr;
  logic [BitW-1:0] ino_bit;
  logic [BitW-1:0] found [MaxFileBlocks];
  logic [1:0]  fail;
  logic [63:0] dtaken;          // bits of the current data word already taken

  always_ff @(posedge clk) begin
    if (rst) begin
      inode_total <= '0;
      data_total <= '0;
      data_base <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INODE_TOTAL: inode_total <= cfg_data[15:0];
        REG_DATA_TOTAL:  data_total <= cfg_data[15:0];
        REG_DATA_BASE:   data_base <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) clr <= '0;
    else if (cmd.clear_step) clr <= clr + 1'b1;
  end

  // masks of searchable bits in the current word, lowest free bit of each
  logic [BitW+1:0] wbase;
  logic [63:0] ifree, dfree;
  logic [6:0]  ipos, dpos;
  logic        nowrd;
  always_comb begin
    logic [BitW+1:0] b;
    wbase = {1'b0, cur, 6'd0};
    ipos = 7'd64;
    dpos = 7'd64;
    for (int k = 63; k >= 0; k--) begin
      b = wbase + (BitW+2)'(k);
      ifree[k] = !irdata[k] && b >= (BitW+2)'(1) && b < (BitW+2)'(inode_total);
      dfree[k] = !drdata[k] && !dtaken[k] && b < (BitW+2)'(data_total);
      if (ifree[k]) ipos = 7'(k);
      if (dfree[k]) dpos = 7'(k);
    end
  end
  assign nowrd = cur[WordAw];

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op <= opcode;
      idx <= word_index;
      too_large <= file_size_bytes > MaxBytes;
      need <= NeedW'((file_size_bytes + 32'(BlockBytes - 1)) >> BlockShift);
      nf <= '0;
      fail <= ST_OK;
      emit_cnt <= '0;
    end
    if (cmd.addr_zero) addr <= '0;
    else if (cmd.addr_inc) addr <= addr + 1'b1;
    if (cmd.rd_inode || cmd.rd_data) cur <= addr;
    if (cmd.rd_data) dtaken <= '0;
    else if (cmd.dat_take) dtaken[dpos[5:0]] <= 1'b1;
    if (cmd.ino_take) ino_bit <= {cur[WordAw-1:0], ipos[5:0]};
    if (state == biba_pkg::S_ISCAN && !sts.ino_hit && sts.ino_end) fail <= ST_NO_INODE;
    if (cmd.dat_take) begin
      found[nf] <= {cur[WordAw-1:0], dpos[5:0]};
      nf <= nf + 1'b1;
    end
    if (state == biba_pkg::S_DSCAN && !sts.dat_hit && sts.dat_end) fail <= ST_NO_DATA;
    if (cmd.emit_inc) emit_cnt <= emit_cnt + 1'b1;
  end

  // memories: one write port, one registered read port each
  logic [WordAw-1:0] raddr;
  logic [WordAw-1:0] draddr;
  logic [WordAw-1:0] mark_w;
  logic [63:0]       mark_bit;
  assign raddr = cmd.rd_req ? idx[WordAw-1:0] : addr[WordAw-1:0];
  assign mark_w = found[addr[3:0]][BitW-1:6];
  assign mark_bit = 64'd1 << found[addr[3:0]][5:0];
  assign draddr = cmd.mark_rd ? mark_w : raddr;

  always_ff @(posedge clk) begin
    if (cmd.clear_step) imem[clr[WordAw-1:0]] <= '0;
    else if (cmd.load_item && opcode == OP_LOAD_INODE &&
             {1'b0, word_index} < (WordAw+1)'(MapWords))
      imem[word_index[WordAw-1:0]] <= word_value;
    else if (cmd.ino_mark)
      imem[ino_bit[BitW-1:6]] <= irdata | (64'd1 << ino_bit[5:0]);
    if (cmd.rd_inode || cmd.rd_req) irdata <= imem[raddr];
  end
  always_ff @(posedge clk) begin
    if (cmd.clear_step) dmem[clr[WordAw-1:0]] <= '0;
    else if (cmd.load_item && opcode == OP_LOAD_DATA &&
             {1'b0, word_index} < (WordAw+1)'(MapWords))
      dmem[word_index[WordAw-1:0]] <= word_value;
    else if (cmd.mark_step)
      dmem[mark_w] <= drdata | mark_bit;
    if (cmd.rd_data || cmd.rd_req || cmd.mark_rd) drdata <= dmem[draddr];
  end

  assign sts.clear_done = clr == (WordAw+1)'(MapWords - 1);
  assign sts.too_large = too_large;
  assign sts.op = op;
  assign sts.ino_hit = !ipos[6];
  assign sts.ino_end = addr > inode_total[15:6] || addr == (WordAw+1)'(MapWords);
  assign sts.dat_hit = !dpos[6];
  assign sts.dat_done = nf + 1'b1 == need;
  assign sts.dat_end = addr > data_total[15:6] || addr == (WordAw+1)'(MapWords) ||
                       nowrd;
  assign sts.need_zero = need == '0;
  assign sts.mark_done = addr[NeedW-1:0] >= need;
  assign sts.emit_last = emit_cnt + 1'b1 == need;

  // result formatting
  always_comb begin
    status = '0; inode_number = '0; block_address = '0;
    is_block = 1'b0; read_value = '0; last = 1'b1;
    if (state == biba_pkg::S_EMIT_ONE) begin
      if (op == OP_ADD_FILE) status = too_large ? ST_TOO_LARGE : fail;
      if ((op == OP_READ_INODE || op == OP_READ_DATA) &&
          {1'b0, idx} < (WordAw+1)'(MapWords))
        read_value = op == OP_READ_INODE ? irdata : drdata;
    end else if (state == biba_pkg::S_EMIT_ST) begin
      inode_number = 16'(ino_bit) + 16'd1;
      last = need == '0;
    end else if (state == biba_pkg::S_EMIT_BLK) begin
      inode_number = 16'(ino_bit) + 16'd1;
      is_block = 1'b1;
      block_address = data_base + 32'(found[emit_cnt[3:0]]);
      last = emit_cnt + 1'b1 == need;
    end
  end
endmodule

/* rtl/biba_checker.sv */
// port-level checks for the allocator
module biba_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic is_block,
  input logic [1:0] status,
  input logic [15:0] inode_number
);
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("input taken while result pending");
  a_block_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_block |-> status == 2'd0 && inode_number != 16'd0)
    else $error("block result without allocation");
  a_fail_no_inode: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != 2'd0 |-> inode_number == 16'd0)
    else $error("failed status carries inode");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
endmodule

bind bitmap_inode_block_allocator_unit biba_checker u_chk (
  .clk, .rst, .in_valid (in_ch.valid), .in_ready (in_ch.ready),
  .out_valid (out_ch.valid), .out_ready (out_ch.ready),
  .is_block (out_ch.is_block), .status (out_ch.status),
  .inode_number (out_ch.inode_number)
);

/* test/bitmap_inode_block_allocator_unit_tb.sv */
// testbench for the bitmap inode/block allocator: directed and random items checked by a scoreboard
`timescale 1ns / 100ps

module bitmap_inode_block_allocator_unit_tb;
  import biba_pkg::*;

  localparam int HoldCycles = 300;
  localparam int IdleLimit  = 20000;
  localparam int TailCycles = 40;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] inode_number;
    logic [31:0] block_address;
    logic        is_block;
    logic [63:0] read_value;
    logic        last;
  } alloc_result_t;

  // shadow copy of both maps and the registers, plus the queue of awaited results
  class alloc_scoreboard;
    logic [63:0]   inode_bits [MapWords];
    logic [63:0]   data_bits [MapWords];
    logic [15:0]   inode_total;
    logic [15:0]   data_total;
    logic [31:0]   data_base;
    alloc_result_t awaited [$];
    int            errors;
    int            items;
    int            checked;
    int            allocs;
    int            rejects;

    function new();
      foreach (inode_bits[i]) begin
        inode_bits[i] = '0;
        data_bits[i]  = '0;
      end
      inode_total = '0;
      data_total  = '0;
      data_base   = '0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_INODE_TOTAL: inode_total = value[15:0];
        REG_DATA_TOTAL:  data_total  = value[15:0];
        REG_DATA_BASE:   data_base   = value;
        default: ;
      endcase
    endfunction

    function void push(logic [1:0] st, logic [15:0] ino, logic [31:0] addr, logic isb,
                       logic [63:0] rv, logic lst);
      alloc_result_t r;
      r.status        = st;
      r.inode_number  = ino;
      r.block_address = addr;
      r.is_block      = isb;
      r.read_value    = rv;
      r.last          = lst;
      awaited.push_back(r);
    endfunction

    // accepted input transfer: update the shadow state and queue its results
    function void note_item(logic [2:0] op, logic [8:0] idx, logic [63:0] val,
                            logic [31:0] size);
      int     ino_bit;
      int     found [MaxFileBlocks];
      int     nf;
      longint need;
      items++;
      case (op)
        OP_LOAD_INODE: begin
          inode_bits[idx] = val;
          push(ST_OK, 0, 0, 0, 0, 1);
        end
        OP_LOAD_DATA: begin
          data_bits[idx] = val;
          push(ST_OK, 0, 0, 0, 0, 1);
        end
        OP_READ_INODE: push(ST_OK, 0, 0, 0, inode_bits[idx], 1);
        OP_READ_DATA:  push(ST_OK, 0, 0, 0, data_bits[idx], 1);
        OP_ADD_FILE: begin
          if (size > MaxBytes) begin
            rejects++;
            push(ST_TOO_LARGE, 0, 0, 0, 0, 1);
            return;
          end
          ino_bit = -1;
          for (int i = 1; i < int'(inode_total) && i < MapWords * 64; i++) begin
            if (!inode_bits[i / 64][i % 64]) begin
              ino_bit = i;
              break;
            end
          end
          if (ino_bit < 0) begin
            rejects++;
            push(ST_NO_INODE, 0, 0, 0, 0, 1);
            return;
          end
          need = (longint'(size) + BlockBytes - 1) / BlockBytes;
          nf = 0;
          for (int i = 0; i < int'(data_total) && i < MapWords * 64 && nf < need; i++) begin
            if (!data_bits[i / 64][i % 64]) begin
              found[nf] = i;
              nf++;
            end
          end
          if (nf < need) begin
            rejects++;
            push(ST_NO_DATA, 0, 0, 0, 0, 1);
            return;
          end
          allocs++;
          inode_bits[ino_bit / 64][ino_bit % 64] = 1'b1;
          for (int b = 0; b < need; b++) data_bits[found[b] / 64][found[b] % 64] = 1'b1;
          push(ST_OK, 16'(ino_bit + 1), 0, 0, 0, need == 0);
          for (int b = 0; b < need; b++)
            push(ST_OK, 16'(ino_bit + 1), data_base + 32'(found[b]), 1, 0, b + 1 == need);
        end
        default: push(ST_OK, 0, 0, 0, 0, 1);
      endcase
    endfunction

    // accepted result transfer: compare with the oldest awaited result
    function void check_result(alloc_result_t got);
      alloc_result_t exp;
      checked++;
      if (awaited.size() == 0) begin
        $error("result with nothing awaited: status %0d", got.status);
        errors++;
        return;
      end
      exp = awaited.pop_front();
      if (got.status !== exp.status) begin
        $error("status expected %0d got %0d", exp.status, got.status);
        errors++;
      end
      if (got.inode_number !== exp.inode_number) begin
        $error("inode_number expected %0d got %0d", exp.inode_number, got.inode_number);
        errors++;
      end
      if (got.block_address !== exp.block_address) begin
        $error("block_address expected %h got %h", exp.block_address, got.block_address);
        errors++;
      end
      if (got.is_block !== exp.is_block) begin
        $error("is_block expected %0d got %0d", exp.is_block, got.is_block);
        errors++;
      end
      if (got.read_value !== exp.read_value) begin
        $error("read_value expected %h got %h", exp.read_value, got.read_value);
        errors++;
      end
      if (got.last !== exp.last) begin
        $error("last expected %0d got %0d", exp.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  biba_in_if  in_ch ();
  biba_out_if out_ch ();
  biba_cfg_if cfg ();

  bitmap_inode_block_allocator_unit uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg)
  );

  alloc_scoreboard sb = new();

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_req       = 0;
  int hold_left      = 0;
  int idle_count     = 0;

  // clock: 10 ns period
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // result side: random stalls, an occasional long hold-off, and checking
  always @(posedge clk) begin
    alloc_result_t got;
    if (hold_req) begin
      hold_req  <= 1'b0;
      hold_left <= HoldCycles;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.status        = out_ch.status;
      got.inode_number  = out_ch.inode_number;
      got.block_address = out_ch.block_address;
      got.is_block      = out_ch.is_block;
      got.read_value    = out_ch.read_value;
      got.last          = out_ch.last;
      sb.check_result(got);
    end
  end

  // watchdog: counts cycles with no transfer on any channel
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
        || (cfg.valid && cfg.ready)) begin
      idle_count <= 0;
    end else begin
      idle_count <= idle_count + 1;
      if (idle_count >= IdleLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // one input transfer, with random idle cycles ahead of it
  task automatic send_item(logic [2:0] op, logic [8:0] idx, logic [63:0] val,
                           logic [31:0] size);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.opcode          <= op;
    in_ch.word_index      <= idx;
    in_ch.word_value      <= val;
    in_ch.file_size_bytes <= size;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_item(op, idx, val, size);
  endtask

  // sender pause until every awaited result has come, then let the block settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    sb.set_reg(idx, value);
  endtask

  task automatic set_layout(logic [31:0] inodes, logic [31:0] blocks, logic [31:0] base);
    write_reg(REG_INODE_TOTAL, inodes);
    write_reg(REG_DATA_TOTAL, blocks);
    write_reg(REG_DATA_BASE, base);
  endtask

  function automatic logic [63:0] rand_word();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // random item: mostly add-file requests, with loads that fill or free map words
  task automatic send_random();
    int          pick;
    logic [2:0]  op;
    logic [8:0]  idx;
    logic [31:0] size;
    pick = $urandom_range(99);
    if (pick < 50)      op = OP_ADD_FILE;
    else if (pick < 62) op = OP_LOAD_INODE;
    else if (pick < 74) op = OP_LOAD_DATA;
    else if (pick < 82) op = OP_READ_INODE;
    else if (pick < 90) op = OP_READ_DATA;
    else                op = 3'($urandom_range(7));
    // small indexes keep loads in the part of the map that gets searched
    idx = ($urandom_range(3) == 0) ? 9'($urandom_range(511)) : 9'($urandom_range(7));
    case ($urandom_range(9))
      0:       size = 0;
      1:       size = $urandom();
      2:       size = MaxBytes + $urandom_range(1, 5000);
      3:       size = BlockBytes * $urandom_range(1, MaxFileBlocks);
      default: size = $urandom_range(1, MaxBytes);
    endcase
    send_item(op, idx, rand_word(), size);
  endtask

  task automatic random_phase(int n, int idle_pct, int stall_pct);
    set_layout($urandom_range(2, 400), $urandom_range(0, 600), $urandom());
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n) send_random();
    drain();
  endtask

  initial begin
    rst             = 1'b1;
    in_ch.valid     <= 1'b0;
    in_ch.opcode    <= OP_READ_INODE;
    in_ch.word_index <= '0;
    in_ch.word_value <= '0;
    in_ch.file_size_bytes <= '0;
    cfg.valid       <= 1'b0;
    cfg.index       <= REG_INODE_TOTAL;
    cfg.data        <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: small layout, every opcode and the size edges
    set_layout(16, 64, 1000);
    send_item(OP_READ_INODE, 9'd511, '0, '0);
    send_item(OP_LOAD_DATA, 9'd511, '1, '1);
    send_item(OP_READ_DATA, 9'd511, '0, '0);
    send_item(OP_ADD_FILE, 0, '0, 0);
    send_item(OP_ADD_FILE, 0, '0, 1);
    send_item(OP_ADD_FILE, 0, '0, BlockBytes);
    send_item(OP_ADD_FILE, 0, '0, BlockBytes + 1);
    send_item(OP_ADD_FILE, 0, '0, MaxBytes);
    send_item(OP_ADD_FILE, 0, '0, MaxBytes + 1);
    send_item(OP_ADD_FILE, 0, '0, 32'hFFFF_FFFF);
    send_item(3'd5, 9'h1AA, 64'hA5A5_5A5A_F0F0_0F0F, 32'h5555_AAAA);
    send_item(3'd6, 0, '0, 0);
    send_item(3'd7, 9'h155, '1, '1);
    // data map still has room: another largest file is allocated
    send_item(OP_ADD_FILE, 0, '0, MaxBytes);
    // inode map full below the total: no free inode
    send_item(OP_LOAD_INODE, 0, '1, 0);
    send_item(OP_ADD_FILE, 0, '0, 1);
    send_item(OP_READ_INODE, 0, '0, 0);
    send_item(OP_LOAD_INODE, 0, 64'h0000_0000_0000_0003, 0);
    send_item(OP_LOAD_DATA, 0, 64'h7FFF_FFFF_FFFF_FFFE, 0);
    send_item(OP_ADD_FILE, 0, '0, 2 * BlockBytes);
    send_item(OP_READ_DATA, 0, '0, 0);
    drain();

    // register extremes: no inodes at all, then a single one, then the largest map
    set_layout(0, 0, 0);
    send_item(OP_ADD_FILE, 0, '0, 0);
    drain();
    set_layout(1, 32768, 32'hFFFF_FFFF);
    send_item(OP_ADD_FILE, 0, '0, 0);
    drain();
    // base near the top so block addresses wrap
    set_layout(32768, 32768, 32'hFFFF_FFFA);
    send_item(OP_LOAD_INODE, 9'd1, '1, 0);
    send_item(OP_ADD_FILE, 0, '0, MaxBytes);
    send_item(OP_ADD_FILE, 0, '0, 5 * BlockBytes);
    drain();
    // empty data region with inodes available
    set_layout(32768, 0, 32'h8000_0000);
    send_item(OP_ADD_FILE, 0, '0, 1);
    send_item(OP_ADD_FILE, 0, '0, 0);
    drain();

    // long hold-off on the result side while items keep coming
    set_layout(200, 400, 32'h0001_0000);
    hold_req = 1'b1;
    repeat (20) send_item(OP_ADD_FILE, 0, '0, $urandom_range(0, 3 * BlockBytes));
    drain();

    random_phase(20, 0, 0);
    random_phase(20, 47, 0);
    random_phase(20, 0, 47);
    random_phase(20, 32, 32);

    repeat (TailCycles) @(posedge clk);
    $display("covered %0d items and %0d results: %0d files allocated, %0d requests refused",
             sb.items, sb.checked, sb.allocs, sb.rejects);
    $display("register extremes, full maps, wrapped addresses and stalls on both sides");
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
